// ===== rtl/core/att_pkg.sv =====
// ----------------------------------------------------------------------------
// att_pkg: shared types and constants for the allocation tracking table
// Kinds, status codes, table geometry and the front-to-back command type.
// ----------------------------------------------------------------------------
package att_pkg;

	localparam int BUCKETS   = 4096;
	localparam int WAYS      = 4;
	localparam int ADDR_BITS = 48;
	localparam int BKT_BITS  = $clog2(BUCKETS);
	localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int SLOT_BITS = BKT_BITS + $clog2(WAYS);
	localparam int LIVE_BITS = 15;

	localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

	typedef enum logic [1:0] {
		KIND_RECORD  = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_UNMAP   = 2'd2,
		KIND_MOVE    = 2'd3
	} kind_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNKNOWN = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] TYPE_MOVED = 2'd2;

	// Classified command from the front part
	typedef struct packed {
		logic                 do_remove;   // look up and remove rm_addr
		logic                 unknown_err; // flag unknown if remove misses
		logic                 do_insert;   // record ins_addr
		logic [ADDR_BITS-1:0] rm_addr;
		logic [ADDR_BITS-1:0] ins_addr;
		logic [31:0]          cnt;
		logic [31:0]          sz;
		logic [1:0]           ty;
	} cmd_t;

	typedef struct packed {
		logic [1:0]           status;
		logic                 replaced;
		logic [LIVE_BITS-1:0] live;
		logic [63:0]          total;
		logic [31:0]          allocs;
		logic [31:0]          rels;
	} res_t;

endpackage

// ===== rtl/core/allocation_tracking_table.sv =====
// ----------------------------------------------------------------------------
// allocation_tracking_table: hashed live-allocation tracker
// Records, releases, unmaps and moves addresses in a bucketed table.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive the event fields and push while full is low;
//   one beat is taken per such edge. The front part registers and classifies
//   the event (release, unmap, record, move with size zero as release).
//   The back part hashes the address in four steps (two 64-bit multiplies,
//   each split into 32x32 partials), latches the bucket, reads the bucket's
//   WAYS entries one way a cycle, then writes back. A release or unmap
//   makes one lookup pass; a record or move makes a remove pass then an
//   insert pass; an event that does nothing goes straight to its result.
//   The back part takes a new event only once the last one's result is
//   registered, while the front part can hold one more; the split
//   multiplies and the one-way-a-cycle bucket read set the pace.
//   Result side is a queue: while empty is low the oldest result is shown,
//   and pop takes it. One result register; when it is not popped the back
//   part holds in its final state and the front part fills, raising full.
//   Reset clears the counters; the back part then runs a clearing pass over
//   all BUCKETS*WAYS entries of the entry memory, with full raised after one
//   beat, before it takes an event.
// ----------------------------------------------------------------------------
module allocation_tracking_table import att_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [1:0]           kind,
	input  logic [ADDR_BITS-1:0] address,
	input  logic [ADDR_BITS-1:0] new_address,
	input  logic [31:0]          elem_count,
	input  logic [31:0]          elem_size,
	input  logic [1:0]           alloc_type,
	output logic                 empty,
	input  logic                 pop,
	output logic [1:0]           status,
	output logic                 replaced,
	output logic [LIVE_BITS-1:0] live_entries,
	output logic [63:0]          total_bytes,
	output logic [31:0]          allocations,
	output logic [31:0]          releases
);

	logic cmd_valid, cmd_ready, res_valid;
	cmd_t cmd;
	res_t res;

	att_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.kind(kind), .address(address), .new_address(new_address),
		.elem_count(elem_count), .elem_size(elem_size), .alloc_type(alloc_type),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
	);

	att_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.cmd(cmd), .res_valid(res_valid), .res_ready(pop), .res(res)
	);

	assign empty        = !res_valid;
	assign status       = res.status;
	assign replaced     = res.replaced;
	assign live_entries = res.live;
	assign total_bytes  = res.total;
	assign allocations  = res.allocs;
	assign releases     = res.rels;

endmodule

// ===== rtl/core/att_front.sv =====
// ----------------------------------------------------------------------------
// att_front: event classification
// Turns one input beat into a remove/insert command for the back part.
// ----------------------------------------------------------------------------
module att_front import att_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [1:0]           kind,
	input  logic [ADDR_BITS-1:0] address,
	input  logic [ADDR_BITS-1:0] new_address,
	input  logic [31:0]          elem_count,
	input  logic [31:0]          elem_size,
	input  logic [1:0]           alloc_type,
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output cmd_t                 cmd
);

	cmd_t cls;
	logic vld_q;
	cmd_t cmd_q;
	logic [1:0] k;

	always_comb begin
		k = kind;
		if (k == KIND_MOVE && elem_size == 32'd0)
			k = KIND_RELEASE;
		cls = '0;
		cls.rm_addr  = address;
		cls.ins_addr = address;
		cls.cnt      = elem_count;
		cls.sz       = elem_size;
		cls.ty       = alloc_type;
		case (k)
			KIND_RECORD: begin
				cls.do_remove = (elem_count != 32'd0) && (elem_size != 32'd0);
				cls.do_insert = cls.do_remove;
			end
			KIND_RELEASE: begin
				cls.do_remove   = (address != '0);
				cls.unknown_err = 1'b1;
			end
			KIND_UNMAP: begin
				cls.do_remove = 1'b1;
			end
			default: begin
				cls.do_remove = 1'b1;
				cls.do_insert = 1'b1;
				cls.ins_addr  = new_address;
				cls.cnt       = 32'd1;
				cls.ty        = TYPE_MOVED;
			end
		endcase
	end

	assign full = vld_q && !cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (push && !full) begin
			vld_q <= 1'b1;
		end else if (cmd_ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full)
			cmd_q <= cls;
	end

	assign cmd_valid = vld_q;
	assign cmd       = cmd_q;

endmodule

// ===== rtl/core/att_hash.sv =====
// ----------------------------------------------------------------------------
// att_hash: four-step bucket hash
// Mixer finaliser reduced to a bucket index; each 64-bit multiply is split
// into 32x32 partial products over two steps.
// ----------------------------------------------------------------------------
module att_hash import att_pkg::*; (
	input  logic                 clk,
	input  logic [ADDR_BITS-1:0] addr,
	input  logic                 step,
	input  logic [1:0]           phase,
	output logic [BKT_BITS-1:0]  bucket
);

	logic [63:0] x0, x1, x2, m1_q, m2_q, op, k;
	logic [63:0] p0_q;
	logic [31:0] p1_q, p2_q, mix;

	assign x0  = 64'(addr) ^ (64'(addr) >> 30);
	assign x1  = m1_q ^ (m1_q >> 27);
	assign x2  = m2_q ^ (m2_q >> 31);
	assign op  = phase[1] ? x1 : x0;
	assign k   = phase[1] ? MIX_C2 : MIX_C1;
	// cross terms only matter in their low 32 bits
	assign mix = p1_q + p2_q;

	always_ff @(posedge clk) begin
		if (step && !phase[0]) begin
			p0_q <= 64'(op[31:0]) * 64'(k[31:0]);
			p1_q <= op[31:0] * k[63:32];
			p2_q <= op[63:32] * k[31:0];
		end
		if (step && phase == 2'd1)
			m1_q <= p0_q + {mix, 32'h0};
		if (step && phase == 2'd3)
			m2_q <= p0_q + {mix, 32'h0};
	end

	assign bucket = x2[BKT_BITS-1:0];

endmodule

// ===== rtl/core/att_back.sv =====
// ----------------------------------------------------------------------------
// att_back: table engine
// Hashes, reads a bucket one way at a time, then writes the entry and counters.
// ----------------------------------------------------------------------------
module att_back import att_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cmd_valid,
	output logic  cmd_ready,
	input  cmd_t  cmd,
	output logic  res_valid,
	input  logic  res_ready,
	output res_t  res
);

	localparam int SLOTS = BUCKETS * WAYS;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_H1, S_H2, S_H3, S_H4, S_BKT, S_RD, S_WR, S_DONE
	} state_t;

	state_t state_q;
	logic   ins_ph_q;              // 0 remove pass, 1 insert pass
	cmd_t   c_q;
	logic [WAY_BITS:0]  way_q;
	logic [BKT_BITS-1:0] bkt_q;
	logic               hit_q, free_found_q, rep_q;
	logic [WAY_BITS-1:0] hit_way_q, free_way_q;
	logic [1:0]         status_q;
	logic [LIVE_BITS-1:0] live_q;
	logic [63:0]        total_q;
	logic [31:0]        allocs_q, rels_q;
	logic               res_vld_q;
	res_t               res_q;
	logic [SLOT_BITS-1:0] clr_q;

	// entry memory: {valid, address}
	logic [ADDR_BITS:0]   ent_mem [SLOTS];
	logic [ADDR_BITS:0]   rd_q;
	logic                 rd_vld_q;
	logic [63:0]          prod_q;

	logic [BKT_BITS-1:0]  bucket;
	logic [ADDR_BITS-1:0] cur_addr;
	logic [SLOT_BITS-1:0] rd_slot, wr_slot;
	logic                 rd_way_ok;
	logic                 h_step;
	logic [1:0]           h_phase;
	logic                 mem_we;
	logic [SLOT_BITS-1:0] mem_wa;
	logic [ADDR_BITS:0]   mem_wd;

	assign cur_addr = ins_ph_q ? c_q.ins_addr : c_q.rm_addr;

	assign h_step = state_q inside {S_H1, S_H2, S_H3, S_H4};

	always_comb begin
		case (state_q)
			S_H2:    h_phase = 2'd1;
			S_H3:    h_phase = 2'd2;
			S_H4:    h_phase = 2'd3;
			default: h_phase = 2'd0;
		endcase
	end

	att_hash u_hash (
		.clk(clk), .addr(cur_addr), .step(h_step), .phase(h_phase), .bucket(bucket)
	);

	assign rd_slot = SLOT_BITS'({bkt_q, way_q[WAY_BITS-1:0]} >> (WAYS > 1 ? 0 : 1));
	assign wr_slot = (ins_ph_q && !hit_q)
	                 ? SLOT_BITS'({bkt_q, free_way_q} >> (WAYS > 1 ? 0 : 1))
	                 : SLOT_BITS'({bkt_q, hit_way_q} >> (WAYS > 1 ? 0 : 1));
	assign rd_way_ok = (way_q < (WAY_BITS+1)'(WAYS));

	// single write port: clearing pass, removal or insertion
	always_comb begin
		mem_we = 1'b0;
		mem_wa = wr_slot;
		mem_wd = {1'b1, c_q.ins_addr};
		if (state_q == S_CLR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else if (state_q == S_WR) begin
			if (!ins_ph_q) begin
				mem_we = hit_q;
				mem_wd = {1'b0, c_q.rm_addr};
			end else begin
				mem_we = hit_q || free_found_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RD && rd_way_ok)
			rd_q <= ent_mem[rd_slot];
		if (mem_we)
			ent_mem[mem_wa] <= mem_wd;
		if (state_q == S_H1)
			prod_q <= 64'(c_q.cnt) * 64'(c_q.sz);
	end

	assign cmd_ready = (state_q == S_IDLE);
	assign res_valid = res_vld_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			live_q    <= '0;
			total_q   <= '0;
			allocs_q  <= '0;
			rels_q    <= '0;
			res_vld_q <= 1'b0;
			ins_ph_q  <= 1'b0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!res_vld_q || res_ready))
				res_vld_q <= 1'b1;
			else if (res_vld_q && res_ready)
				res_vld_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cmd_valid) begin
						c_q      <= cmd;
						rep_q    <= 1'b0;
						status_q <= ST_OK;
						ins_ph_q <= !cmd.do_remove;
						state_q  <= (cmd.do_remove || cmd.do_insert) ? S_H1 : S_DONE;
					end
				end
				S_H1: state_q <= S_H2;
				S_H2: state_q <= S_H3;
				S_H3: state_q <= S_H4;
				S_H4: state_q <= S_BKT;
				S_BKT: begin
					bkt_q        <= bucket;
					way_q        <= '0;
					hit_q        <= 1'b0;
					free_found_q <= 1'b0;
					rd_vld_q     <= 1'b0;
					state_q      <= S_RD;
				end
				S_RD: begin
					// check previous way's data while reading the next
					if (rd_vld_q) begin
						if (rd_q[ADDR_BITS] && rd_q[ADDR_BITS-1:0] == cur_addr && !hit_q) begin
							hit_q     <= 1'b1;
							hit_way_q <= WAY_BITS'(way_q - 1'b1);
						end
						if (!rd_q[ADDR_BITS] && !free_found_q) begin
							free_found_q <= 1'b1;
							free_way_q   <= WAY_BITS'(way_q - 1'b1);
						end
					end
					rd_vld_q <= rd_way_ok;
					way_q    <= way_q + 1'b1;
					if (!rd_way_ok)
						state_q <= S_WR;
				end
				S_WR: begin
					if (!ins_ph_q) begin
						if (hit_q) begin
							rep_q <= 1'b1;
							if (rels_q != '1) rels_q <= rels_q + 1'b1;
							if (live_q != '0) live_q <= live_q - 1'b1;
						end else if (c_q.unknown_err) begin
							status_q <= ST_UNKNOWN;
						end
						if (c_q.do_insert) begin
							ins_ph_q <= 1'b1;
							state_q  <= S_H1;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						if (hit_q || free_found_q) begin
							// a held entry for the destination is replaced in place
							total_q <= total_q + prod_q;
							if (allocs_q != '1) allocs_q <= allocs_q + 1'b1;
							if (hit_q) begin
								rep_q <= 1'b1;
								if (rels_q != '1) rels_q <= rels_q + 1'b1;
							end else begin
								live_q <= live_q + 1'b1;
							end
						end else begin
							status_q <= ST_FULL;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!res_vld_q || res_ready) begin
						res_q <= '{status: status_q, replaced: rep_q, live: live_q,
						           total: total_q, allocs: allocs_q, rels: rels_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
